FILE: hdl/srr_pkg.sv
// shared types and constants for the selective-repeat receiver window
// no dependencies; used by selective_repeat_receiver
package srr_pkg;

  // sequence space, power of two so offsets wrap by truncation
  localparam int SEQ_COUNT     = 8;
  localparam int WINDOW        = 4;
  localparam int PAYLOAD_WIDTH = 64;

  // fixed port widths
  localparam int SEQ_NUM_W  = 3;
  localparam int DATA_W     = 64;
  localparam int KIND_W     = 2;

  // derived widths
  localparam int SLOT_W = $clog2(SEQ_COUNT);
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // result kind codes
  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK_OK  = 2'd1,
    KIND_ACK_ERR = 2'd2
  } kind_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [PAYLOAD_WIDTH-1:0] payload_t;

endpackage

FILE: hdl/selective_repeat_receiver.sv
// selective-repeat receiver window: payload buffer in a synchronous memory,
// held flags in flops, one result word per cycle when the output is not stalled; depends on srr_pkg
//
//  channel  direction  signals
//  in       sink       in_valid_i/in_ready_o, seq_num_i, checksum_ok_i, payload_word_i
//  out      source     out_valid_o/out_ready_i, kind_o, data_word_o, ack_number_o, last_o
//
// a packet with bad checksum gives no result word
// out-of-window and buffered packets give one ack word
// an in-order packet gives 1 + run + 1 words (at most WINDOW + 1), one word
//   a cycle while the output is not stalled, through the single output register;
//   buffered payloads come from the memory read port, addressed one slot ahead
// a stall on the output holds the sequencer and the read address in place
// reset clears the window base, the held flags and the output valid flag
module selective_repeat_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [srr_pkg::SEQ_NUM_W-1:0]  seq_num_i,
  input  logic                           checksum_ok_i,
  input  logic [srr_pkg::DATA_W-1:0]     payload_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [srr_pkg::KIND_W-1:0]     kind_o,
  output logic [srr_pkg::DATA_W-1:0]     data_word_o,
  output logic [srr_pkg::SEQ_NUM_W-1:0]  ack_number_o,
  output logic                           last_o
);

  // control state
  srr_pkg::state_e                state_q, state_d;
  srr_pkg::slot_t                 base_q, base_d;
  srr_pkg::slot_t                 slot_q, slot_d;
  logic [srr_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [srr_pkg::SEQ_COUNT-1:0]  held_q, held_d;
  logic [srr_pkg::SEQ_NUM_W-1:0]  seq_q, seq_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  srr_pkg::kind_e                 out_kind_q, out_kind_d;
  srr_pkg::payload_t              out_data_q, out_data_d;
  logic [srr_pkg::SEQ_NUM_W-1:0]  out_ack_q, out_ack_d;
  logic                           out_last_q, out_last_d;

  // payload memory
  srr_pkg::payload_t              mem_q [srr_pkg::SEQ_COUNT];
  srr_pkg::payload_t              rd_q;
  logic                           mem_we;

  // decode of the arriving word
  srr_pkg::slot_t                 seq_idx;
  srr_pkg::slot_t                 offset;
  srr_pkg::payload_t              in_payload;
  logic                           in_space;
  logic                           in_window;
  logic                           in_accept;
  logic                           out_free;
  logic                           run_more;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == srr_pkg::S_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  assign seq_idx    = srr_pkg::SLOT_W'(seq_num_i);
  assign offset     = seq_idx - base_q;
  assign in_payload = payload_word_i[srr_pkg::PAYLOAD_WIDTH-1:0];
  assign in_space   = int'(seq_num_i) < srr_pkg::SEQ_COUNT;
  assign in_window  = in_space && (int'(offset) < srr_pkg::WINDOW);

  // the run goes on while the next slot is held and the window is not used up
  assign run_more = held_q[slot_q] && (int'(cnt_q) < srr_pkg::WINDOW);

  // sequencer
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    held_d      = held_q;
    seq_d       = seq_q;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_ack_d   = out_ack_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      srr_pkg::S_IDLE: begin
        if (in_accept && checksum_ok_i) begin
          out_valid_d = 1'b1;
          out_ack_d   = seq_num_i;
          out_data_d  = '0;
          out_last_d  = 1'b1;
          if (!in_window) begin
            out_kind_d = srr_pkg::KIND_ACK_ERR;
          end else if (offset == '0) begin
            // in-order packet: deliver it, then walk the held run
            out_kind_d     = srr_pkg::KIND_DELIVER;
            out_data_d     = in_payload;
            out_last_d     = 1'b0;
            held_d[base_q] = 1'b0;
            slot_d         = base_q + srr_pkg::SLOT_W'(1);
            cnt_d          = srr_pkg::CNT_W'(1);
            seq_d          = seq_num_i;
            state_d        = srr_pkg::S_RUN;
          end else begin
            // early packet: buffer it and ack
            out_kind_d      = srr_pkg::KIND_ACK_OK;
            mem_we          = 1'b1;
            held_d[seq_idx] = 1'b1;
          end
        end
      end
      srr_pkg::S_RUN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ack_d   = seq_q;
          if (run_more) begin
            out_kind_d     = srr_pkg::KIND_DELIVER;
            out_data_d     = rd_q;
            out_last_d     = 1'b0;
            held_d[slot_q] = 1'b0;
            slot_d         = slot_q + srr_pkg::SLOT_W'(1);
            cnt_d          = cnt_q + srr_pkg::CNT_W'(1);
          end else begin
            out_kind_d = srr_pkg::KIND_ACK_OK;
            out_data_d = '0;
            out_last_d = 1'b1;
            base_d     = slot_q;
            state_d    = srr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = srr_pkg::S_IDLE;
      end
    endcase
  end

  // control and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srr_pkg::S_IDLE;
      base_q      <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
    out_ack_q  <= out_ack_d;
    out_last_q <= out_last_d;
  end

  // payload memory, read one slot ahead of the run
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[seq_idx] <= in_payload;
    end
    rd_q <= mem_q[slot_d];
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign data_word_o  = srr_pkg::DATA_W'(out_data_q);
  assign ack_number_o = out_ack_q;
  assign last_o       = out_last_q;

  // run length never goes past the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= srr_pkg::WINDOW)
    else $error("run counter beyond window");

  // only acks close a packet's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_kind_q != srr_pkg::KIND_DELIVER)))
    else $error("last flag does not match result kind");

  // the window base moves only at the end of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srr_pkg::S_IDLE) |=> $stable(base_q))
    else $error("window base moved outside a run");

  // the delivered base slot is no longer held during its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srr_pkg::S_RUN) |-> !held_q[base_q])
    else $error("base slot still held during run");

endmodule
